// ===== sv/sha_pkg.sv =====
package sha_pkg;

  // Table sizing
  localparam int CAPACITY   = 256;
  localparam int WORD_W     = 32;
  localparam int HANDLE_W   = 8;
  localparam int OUT_WORD_W = 32;
  localparam int NUM_SLOTS  = 1 << HANDLE_W;
  localparam int SLOT_LIMIT = (CAPACITY < NUM_SLOTS) ? CAPACITY : NUM_SLOTS;
  localparam int COUNT_W    = HANDLE_W + 1;

  // Request and result queues; depth must be a power of two
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Classified request, front to back
  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   word;
    logic                word_zero;
  } req_t;

  // Result, back to result queue
  typedef struct packed {
    logic [HANDLE_W-1:0]   handle;
    logic [OUT_WORD_W-1:0] word;
    logic                  is_valid;
    status_e               status;
  } res_t;

endpackage

// ===== sv/sha_ram.sv =====
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/sha_front.sv =====
module sha_front import sha_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [31:0]         obj_word_i,
  output logic                req_valid_o,
  output req_t                req_o,
  input  logic                req_pop_i
);

  req_t              entry_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;
  req_t              new_req;

  assign full        = (count_q == QCNT_W'(Q_DEPTH));
  assign req_valid_o = (count_q != '0);
  assign req_o       = entry_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = req_pop_i && req_valid_o;

  // Classify: mask the word to the stored width and flag a zero word
  always_comb begin
    new_req.op        = op_e'(op_i);
    new_req.handle    = handle_i;
    new_req.word      = WORD_W'(obj_word_i);
    new_req.word_zero = (WORD_W'(obj_word_i) == '0);
  end

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= new_req;
    end
  end

endmodule

// ===== sv/sha_back.sv =====
module sha_back import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_t req_i,
  output logic req_pop_o,
  input  logic res_space_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_q, state_d;
  req_t                 cur_q, cur_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [HANDLE_W-1:0]  head_q, head_d;
  logic [HANDLE_W-1:0]  tail_q, tail_d;
  logic [COUNT_W-1:0]   level_q, level_d;
  logic [COUNT_W-1:0]   next_q, next_d;

  logic                 slot_we;
  logic [HANDLE_W-1:0]  slot_waddr;
  logic [WORD_W-1:0]    slot_rdata;
  logic                 fifo_we;
  logic [HANDLE_W-1:0]  fifo_rdata;

  logic                 in_range;
  logic                 hvalid;
  logic                 start;

  assign start     = (state_q == S_IDLE) && req_valid_i && res_space_i;
  assign req_pop_o = start;

  assign in_range = ({1'b0, cur_q.handle} < COUNT_W'(SLOT_LIMIT));
  assign hvalid   = (cur_q.handle != '0) && in_range && valid_q[cur_q.handle];

  // Slot words; a slot whose valid bit is clear reads as zero
  sha_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (cur_q.word),
    .raddr_i (req_i.handle),
    .rdata_o (slot_rdata)
  );

  // Freed handles, oldest at head
  sha_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (NUM_SLOTS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail_q),
    .wdata_i (cur_q.handle),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  // Execute: reads issued on start, acted on in the next cycle in S_EXEC
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    valid_d      = valid_q;
    head_d       = head_q;
    tail_d       = tail_q;
    level_d      = level_q;
    next_d       = next_q;
    slot_we      = 1'b0;
    slot_waddr   = cur_q.handle;
    fifo_we      = 1'b0;
    res_push_o   = 1'b0;
    res_o.handle = cur_q.handle;
    res_o.word   = '0;
    res_o.is_valid = 1'b0;
    res_o.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cur_d   = req_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
        case (cur_q.op)
          OP_ADD: begin
            res_o.handle = '0;
            if (cur_q.word_zero) begin
              res_o.status = ST_INVALID;
            end else if (level_q != '0) begin
              res_o.handle        = fifo_rdata;
              res_o.is_valid      = 1'b1;
              head_d              = head_q + 1'b1;
              level_d             = level_q - 1'b1;
              next_d              = next_q + 1'b1;
              slot_we             = 1'b1;
              slot_waddr          = fifo_rdata;
              valid_d[fifo_rdata] = 1'b1;
            end else if (next_q >= COUNT_W'(SLOT_LIMIT)) begin
              res_o.status = ST_FULL;
            end else begin
              res_o.handle                  = next_q[HANDLE_W-1:0];
              res_o.is_valid                = 1'b1;
              next_d                        = next_q + 1'b1;
              slot_we                       = 1'b1;
              slot_waddr                    = next_q[HANDLE_W-1:0];
              valid_d[next_q[HANDLE_W-1:0]] = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (hvalid) begin
              res_o.is_valid        = 1'b1;
              valid_d[cur_q.handle] = 1'b0;
              if (next_q != '0) begin
                next_d = next_q - 1'b1;
              end
              // queue the handle unless the free list is full
              if (level_q < COUNT_W'(NUM_SLOTS)) begin
                fifo_we = 1'b1;
                tail_d  = tail_q + 1'b1;
                level_d = level_q + 1'b1;
              end
            end else begin
              res_o.status = ST_INVALID;
            end
          end
          OP_GET: begin
            res_o.is_valid = hvalid;
            if (in_range) begin
              if (valid_q[cur_q.handle]) begin
                res_o.word = OUT_WORD_W'(slot_rdata);
              end
            end else begin
              res_o.status = ST_INVALID;
            end
          end
          default: begin
            res_o.is_valid = hvalid;
            res_o.status   = hvalid ? ST_OK : ST_INVALID;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
      next_q  <= COUNT_W'(1);
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
      next_q  <= next_d;
    end
  end

  // Request under execution
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ===== sv/sha_resq.sv =====
module sha_resq import sha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_push_i,
  input  res_t                  res_i,
  output logic                  res_space_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [HANDLE_W-1:0]   out_handle_o,
  output logic [OUT_WORD_W-1:0] out_word_o,
  output logic                  is_valid_o,
  output logic [1:0]            status_o
);

  res_t              entry_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;
  res_t              head;

  assign res_space_o  = (count_q != QCNT_W'(Q_DEPTH));
  assign empty        = (count_q == '0);
  assign do_pop       = pop && !empty;
  assign head         = entry_q[rd_ptr_q];
  assign out_handle_o = head.handle;
  assign out_word_o   = head.word;
  assign is_valid_o   = head.is_valid;
  assign status_o     = head.status;

  // Pointer and fill bookkeeping; back only pushes when there is room
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (res_push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({res_push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== sv/slot_handle_allocator.sv =====
// Channel   Handshake             Payload
// request   push / full           op_i, handle_i, obj_word_i
// result    empty / pop           out_handle_o, out_word_o, is_valid_o, status_o
//
// In the executor, S_IDLE issues the reads of the slot RAM and the free-handle
// RAM on start, and S_EXEC acts on the read data and writes back.
// Requests wait in a two-entry queue ahead of the executor, results in a
// two-entry queue behind it; the executor starts a request only when the
// result queue has room, so a stalled pop backs up into full.
// Reset clears slot valid bits and free-list pointers and sets the next-handle counter to 1 at once.
module slot_handle_allocator import sha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            op_i,
  input  logic [HANDLE_W-1:0]   handle_i,
  input  logic [31:0]           obj_word_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [HANDLE_W-1:0]   out_handle_o,
  output logic [OUT_WORD_W-1:0] out_word_o,
  output logic                  is_valid_o,
  output logic [1:0]            status_o
);

  logic req_valid;
  req_t req;
  logic req_pop;
  logic res_space;
  logic res_push;
  res_t res;

  // Request queue and classification
  sha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .handle_i    (handle_i),
    .obj_word_i  (obj_word_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  // Table executor
  sha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .res_space_i (res_space),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue
  sha_resq u_resq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_push_i   (res_push),
    .res_i        (res),
    .res_space_o  (res_space),
    .empty        (empty),
    .pop          (pop),
    .out_handle_o (out_handle_o),
    .out_word_o   (out_word_o),
    .is_valid_o   (is_valid_o),
    .status_o     (status_o)
  );

endmodule
